### rtl/disk_request_elevator_queue_unit_defines.svh
// assertion macros for the queue unit rtl file
`ifndef DISK_REQUEST_ELEVATOR_QUEUE_UNIT_DEFINES_SVH
`define DISK_REQUEST_ELEVATOR_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DREQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DREQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dreq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dreq_pkg;

  // input beat
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] block_number;
    logic [3:0]  unit_select;
    logic [7:0]  request_tag;
  } req_t;

  // result beat
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  result_tag;
    logic [15:0] disk_address;
    logic        last;
  } result_t;

  // queue entry, address is computed at submit time
  typedef struct packed {
    logic [15:0] block;
    logic [15:0] addr;
    logic [7:0]  tag;
  } entry_t;

  localparam logic [1:0] ModeSubmit   = 2'd0;
  localparam logic [1:0] ModeDoneOk   = 2'd1;
  localparam logic [1:0] ModeDoneErr  = 2'd2;
  localparam logic [1:0] ModeReserved = 2'd3;

  localparam logic [2:0] KindStart    = 3'd0;
  localparam logic [2:0] KindDoneOk   = 3'd1;
  localparam logic [2:0] KindDoneErr  = 3'd2;
  localparam logic [2:0] KindBadRange = 3'd3;
  localparam logic [2:0] KindFull     = 3'd4;

  localparam logic CfgBlocksPerDrive = 1'b0;
  localparam logic CfgRetryLimit     = 1'b1;

  localparam logic [12:0] BlocksPerDriveReset = 13'd4872;
  localparam logic [3:0]  RetryLimitReset     = 4'd10;
  localparam logic [3:0]  UnitSingleMax       = 4'd7;
  localparam logic [3:0]  SectorsPerTrack     = 4'd12;

  // shared divider geometry
  localparam int unsigned DivWidth    = 16;
  localparam int unsigned DivisorBits = 4;

endpackage
`default_nettype wire

### rtl/dreq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module dreq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/dreq_div.sv
`timescale 1ns / 1ps
`default_nettype none
module dreq_div (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic [dreq_pkg::DivWidth-1:0]         dividend_i,
  input  wire logic [dreq_pkg::DivisorBits-1:0]      divisor_i,
  output logic                                       done_o,
  output logic      [dreq_pkg::DivWidth-1:0]         quot_o,
  output logic      [dreq_pkg::DivisorBits-1:0]      rem_o
);
  import dreq_pkg::*;

  localparam int unsigned CntW = $clog2(DivWidth + 1);

  logic                   run_q, run_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [DivWidth-1:0]    quot_q, quot_d;
  logic [DivisorBits-1:0] rem_q, rem_d;
  logic [DivisorBits-1:0] dvs_q, dvs_d;
  logic [DivisorBits:0]   trial;
  logic [DivisorBits:0]   diff;
  logic                   fits;

  // one restoring step a cycle, msb first
  always_comb begin
    trial  = {rem_q, quot_q[DivWidth-1]};
    diff   = trial - {1'b0, dvs_q};
    fits   = trial >= {1'b0, dvs_q};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = CntW'(DivWidth);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (run_q) begin
      rem_d  = fits ? diff[DivisorBits-1:0] : trial[DivisorBits-1:0];
      quot_d = {quot_q[DivWidth-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

### rtl/disk_request_elevator_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// submit: check, divider run (twice when interleaved), scan of the queue, a move per entry shifted,
//   write of the new entry, then the head is started when no transfer is active; results are registered
// completion: check, report, pop that moves each remaining entry forward, then start of the
//   next head if any; a retried error takes a check and then restarts the head
// one item at a time, set by the 16-step shared divider and the single queue ram port;
// the receiver cannot stall; async active-low reset: empty queue, idle, registers 4872 and 10
module disk_request_elevator_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire dreq_pkg::req_t    in_i,
  output logic                   result_valid_o,
  output dreq_pkg::result_t      result_o,
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_index_i,
  input  wire logic [12:0]       cfg_data_i
);
  import dreq_pkg::*;
  `include "disk_request_elevator_queue_unit_defines.svh"

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    IDLE, CHECK, DIV_M, DIV_T, SCAN_FIRST, SCAN, SHIFT_RD, SHIFT_WR,
    HEAD_RD, HEAD_OUT, FIN_RD, FIN_OUT, POP_RD, POP_WR
  } state_e;

  state_e        state_q, state_d;
  req_t          req_q, req_d;
  logic [CW-1:0] count_q, count_d;
  logic          active_q, active_d;
  logic [3:0]    err_q, err_d;
  logic [12:0]   bpd_q, bpd_d;
  logic [3:0]    rlim_q, rlim_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [15:0]   prev_q, prev_d;
  logic [2:0]    drive_q, drive_d;
  logic [15:0]   addr_q, addr_d;
  logic [2:0]    kind_q, kind_d;
  logic          res_valid_q, res_valid_d;
  result_t       res_q, res_d;

  logic                   div_start;
  logic [DivWidth-1:0]    div_dividend;
  logic [DivisorBits-1:0] div_divisor;
  logic                   div_done;
  logic [DivWidth-1:0]    div_quot;
  logic [DivisorBits-1:0] div_rem;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  logic          interleave;
  logic [3:0]    span;
  logic [16:0]   range_limit;
  logic          hit;
  logic [4:0]    err_next;

  dreq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  dreq_ram #(
    .Width ($bits(entry_t)),
    .Depth (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // range bound and elevator compare
  always_comb begin
    interleave  = req_q.unit_select > UnitSingleMax;
    span        = (req_q.unit_select > 4'd8) ? (req_q.unit_select - UnitSingleMax) : 4'd1;
    range_limit = 17'(bpd_q) * 17'(span);
    hit = ((prev_q <= req_q.block_number) && (req_q.block_number < ram_rdata.block)) ||
          ((prev_q >= req_q.block_number) && (req_q.block_number > ram_rdata.block));
    err_next = {1'b0, err_q} + 5'd1;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    count_d      = count_q;
    active_d     = active_q;
    err_d        = err_q;
    bpd_d        = bpd_q;
    rlim_d       = rlim_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    prev_d       = prev_q;
    drive_d      = drive_q;
    addr_d       = addr_q;
    kind_d       = kind_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    div_start    = 1'b0;
    div_dividend = req_q.block_number;
    div_divisor  = SectorsPerTrack;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = ram_rdata;
    ram_raddr    = '0;

    // config writes
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgBlocksPerDrive: bpd_d  = cfg_data_i;
        CfgRetryLimit:     rlim_d = cfg_data_i[3:0];
        default:           ;
      endcase
    end

    unique case (state_q)
      IDLE: begin
        if (start) begin
          req_d   = in_i;
          state_d = CHECK;
        end
      end
      CHECK: begin
        if (req_q.mode == ModeSubmit) begin
          if ({1'b0, req_q.block_number} >= range_limit) begin
            res_valid_d = 1'b1;
            res_d       = '{KindBadRange, req_q.request_tag, 16'd0, 1'b1};
            state_d     = IDLE;
          end else if (count_q == CW'(QUEUE_DEPTH)) begin
            res_valid_d = 1'b1;
            res_d       = '{KindFull, req_q.request_tag, 16'd0, 1'b1};
            state_d     = IDLE;
          end else begin
            div_start = 1'b1;
            if (interleave) begin
              div_divisor = req_q.unit_select - UnitSingleMax;
              state_d     = DIV_M;
            end else begin
              drive_d = req_q.unit_select[2:0];
              state_d = DIV_T;
            end
          end
        end else if ((req_q.mode == ModeDoneOk || req_q.mode == ModeDoneErr) &&
                     active_q && count_q != '0) begin
          active_d = 1'b0;
          if (req_q.mode == ModeDoneErr && err_next <= {1'b0, rlim_q}) begin
            err_d   = err_next[3:0];
            state_d = HEAD_RD;
          end else begin
            kind_d  = (req_q.mode == ModeDoneErr) ? KindDoneErr : KindDoneOk;
            err_d   = '0;
            state_d = FIN_RD;
          end
        end else begin
          state_d = IDLE;
        end
      end
      DIV_M: begin
        if (div_done) begin
          drive_d      = div_rem[2:0];
          div_start    = 1'b1;
          div_dividend = div_quot;
          state_d      = DIV_T;
        end
      end
      DIV_T: begin
        if (div_done) begin
          addr_d = {drive_q, 13'd0} | {div_quot[11:0], 4'd0} | {12'd0, div_rem};
          pos_d  = count_q[AW-1:0];
          idx_d  = count_q;
          if (count_q >= CW'(2)) begin
            state_d = SCAN_FIRST;
          end else begin
            state_d = SHIFT_RD;
          end
        end
      end
      SCAN_FIRST: begin
        ram_raddr = '0;
        idx_d     = '0;
        state_d   = SCAN;
      end
      // walk pairs of neighbors for the first gap the new block falls in
      SCAN: begin
        ram_raddr = idx_q[AW-1:0] + 1'b1;
        if (idx_q == '0) begin
          prev_d = ram_rdata.block;
          idx_d  = CW'(1);
        end else if (hit) begin
          pos_d   = idx_q[AW-1:0];
          idx_d   = count_q;
          state_d = SHIFT_RD;
        end else if (idx_q + 1'b1 == count_q) begin
          pos_d   = count_q[AW-1:0];
          idx_d   = count_q;
          state_d = SHIFT_RD;
        end else begin
          prev_d = ram_rdata.block;
          idx_d  = idx_q + 1'b1;
        end
      end
      // open a slot at the insert position, tail first
      SHIFT_RD: begin
        if (idx_q[AW-1:0] == pos_q) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q;
          ram_wdata = '{req_q.block_number, addr_q, req_q.request_tag};
          count_d   = count_q + 1'b1;
          state_d   = active_q ? IDLE : HEAD_RD;
        end else begin
          ram_raddr = idx_q[AW-1:0] - 1'b1;
          state_d   = SHIFT_WR;
        end
      end
      SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        idx_d     = idx_q - 1'b1;
        state_d   = SHIFT_RD;
      end
      HEAD_RD: begin
        ram_raddr = '0;
        state_d   = HEAD_OUT;
      end
      HEAD_OUT: begin
        res_valid_d = 1'b1;
        res_d       = '{KindStart, ram_rdata.tag, ram_rdata.addr, 1'b1};
        active_d    = 1'b1;
        state_d     = IDLE;
      end
      FIN_RD: begin
        ram_raddr = '0;
        state_d   = FIN_OUT;
      end
      FIN_OUT: begin
        res_valid_d = 1'b1;
        res_d       = '{kind_q, ram_rdata.tag, 16'd0, count_q == CW'(1)};
        idx_d       = CW'(1);
        state_d     = POP_RD;
      end
      // close the head slot, front first
      POP_RD: begin
        if (idx_q == count_q) begin
          count_d = count_q - 1'b1;
          state_d = (count_q > CW'(1)) ? HEAD_RD : IDLE;
        end else begin
          ram_raddr = idx_q[AW-1:0];
          state_d   = POP_WR;
        end
      end
      POP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0] - 1'b1;
        ram_wdata = ram_rdata;
        idx_d     = idx_q + 1'b1;
        state_d   = POP_RD;
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      count_q     <= '0;
      active_q    <= 1'b0;
      err_q       <= '0;
      bpd_q       <= BlocksPerDriveReset;
      rlim_q      <= RetryLimitReset;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      active_q    <= active_d;
      err_q       <= err_d;
      bpd_q       <= bpd_d;
      rlim_q      <= rlim_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    prev_q  <= prev_d;
    drive_q <= drive_d;
    addr_q  <= addr_d;
    kind_q  <= kind_d;
    res_q   <= res_d;
  end

  assign busy           = state_q != IDLE;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `DREQ_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(QUEUE_DEPTH), "queue count above depth")
  `DREQ_ASSERT_NOW(a_active_has_head, clk_i, rst_ni, active_q, count_q != '0, "transfer active with empty queue")
  `DREQ_ASSERT_NOW(a_start_sets_active, clk_i, rst_ni, result_valid_o && result_o.kind == KindStart, active_q, "start beat without active transfer")
  `DREQ_ASSERT_NEXT(a_div_once, clk_i, rst_ni, div_start, !div_start, "divider restarted while running")

endmodule
`default_nettype wire
